// ===== src/mlvw_pkg.sv =====
// ----------------------------------------------------------------------------
// mlvw_pkg: shared types, constants and the function of the vertex warp
// Register map, side codes, reset values and the final output rounding.
// ----------------------------------------------------------------------------
package mlvw_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_W         = 43;

    localparam logic [16:0] Q16_ONE = 17'd65536;

    localparam logic [14:0] WIN_W_RST     = 15'd640;
    localparam logic [14:0] WIN_H_RST     = 15'd480;
    localparam logic [10:0] ICON_SIZE_RST = 11'd40;

    typedef enum logic [2:0] {
        CFG_WIN_X     = 3'd0,
        CFG_WIN_Y     = 3'd1,
        CFG_WIN_W     = 3'd2,
        CFG_WIN_H     = 3'd3,
        CFG_ICON_X    = 3'd4,
        CFG_ICON_Y    = 3'd5,
        CFG_ICON_SIZE = 3'd6,
        CFG_SIDE      = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SIDE_BOTTOM = 2'd0,
        SIDE_TOP    = 2'd1,
        SIDE_LEFT   = 2'd2,
        SIDE_RIGHT  = 2'd3
    } t_side;

    // Rounds a Q16 position to Q8 with ties away from zero and saturates.
    function automatic logic signed [23:0] round_out(input logic signed [ACC_W-1:0] v);
        logic             neg;
        logic [ACC_W-1:0] mag;
        logic [34:0]      m8;
        logic signed [23:0] res;
        neg = v[ACC_W-1];
        mag = neg ? ACC_W'(-v) : ACC_W'(v);
        m8  = 35'((mag + ACC_W'(128)) >> 8);
        if (!neg) begin
            res = (m8 > 35'd8388607) ? 24'sh7FFFFF : 24'(m8);
        end else begin
            res = (m8 > 35'd8388608) ? 24'sh800000 : 24'(-m8);
        end
        return res;
    endfunction

endpackage

// ===== src/magic_lamp_vertex_warp.sv =====
// ----------------------------------------------------------------------------
// magic_lamp_vertex_warp: magic-lamp deformation of one mesh vertex
// The path from start to o_done runs through two bit-per-stage dividers, one for
// the cube ratio and one for the blend factor.
// Throughput is one item per cycle; busy never rises and the receiver cannot stall.
// Synchronous active-low reset clears the valid bits and restores the configuration registers.
// ----------------------------------------------------------------------------
module magic_lamp_vertex_warp import mlvw_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [16:0]        i_tex_u,
    input  logic [16:0]        i_tex_v,
    input  logic [16:0]        i_progress,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    output logic               o_done,
    output logic signed [23:0] o_out_x,
    output logic signed [23:0] o_out_y
);

    localparam int F   = FRAC_BITS;
    localparam int R1W = F + 1;
    localparam int R2W = 2 * F + 2;
    localparam int OW  = 35 + F;
    localparam int BLW = 34 + F;
    localparam int BLO = BLW / 2;
    localparam int BHI = BLW - BLO;
    localparam int LOW = 34 + BLO;
    localparam int HIW = 34 + BHI;
    localparam int PW  = 68 + F;
    localparam int T1W = 100;
    localparam int T2W = 85;

    localparam logic [R1W-1:0] ONE_R   = R1W'(1) << F;
    localparam logic [R2W-1:0] HALF_R2 = R2W'(1) << (F - 1);
    localparam logic [OW-1:0]  HALF_O  = OW'(1) << (F - 1);
    localparam logic [BLW-1:0] ONE_BL  = BLW'(1) << F;
    localparam logic [PW-1:0]  HALF_P  = PW'(1) << (F - 1);
    localparam logic [PW-1:0]  P_CAP   = PW'(1) << 40;

    // Configuration registers.
    logic signed [15:0] r_win_x, r_win_y, r_icon_x, r_icon_y;
    logic [14:0]        r_win_w, r_win_h;
    logic [10:0]        r_icon_size;
    t_side              r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_x     <= '0;
            r_win_y     <= '0;
            r_win_w     <= WIN_W_RST;
            r_win_h     <= WIN_H_RST;
            r_icon_x    <= '0;
            r_icon_y    <= '0;
            r_icon_size <= ICON_SIZE_RST;
            r_side      <= SIDE_BOTTOM;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIN_X:     r_win_x     <= i_cfg_wdata;
                CFG_WIN_Y:     r_win_y     <= i_cfg_wdata;
                CFG_WIN_W:     r_win_w     <= i_cfg_wdata[14:0];
                CFG_WIN_H:     r_win_h     <= i_cfg_wdata[14:0];
                CFG_ICON_X:    r_icon_x    <= i_cfg_wdata;
                CFG_ICON_Y:    r_icon_y    <= i_cfg_wdata;
                CFG_ICON_SIZE: r_icon_size <= i_cfg_wdata[10:0];
                CFG_SIDE:      r_side      <= t_side'(i_cfg_wdata[1:0]);
                default: ;
            endcase
        end
    end

    // Side-dependent configuration view; the user must change it only while idle; unenforced.
    logic               c_vert, c_tpos, c_lenz;
    logic [14:0]        c_len, c_lenc;
    logic signed [15:0] c_wa, c_wc, c_ia, c_ic;
    logic [30:0]        c_lq;
    logic signed [16:0] c_dpix;
    logic signed [35:0] c_apx, c_spx, c_lim;

    always_comb begin
        c_vert = (r_side == SIDE_BOTTOM) || (r_side == SIDE_TOP);
        c_tpos = (r_side == SIDE_BOTTOM) || (r_side == SIDE_RIGHT);
        c_len  = c_vert ? r_win_h : r_win_w;
        c_lenc = c_vert ? r_win_w : r_win_h;
        c_wa   = c_vert ? r_win_y : r_win_x;
        c_wc   = c_vert ? r_win_x : r_win_y;
        c_ia   = c_vert ? r_icon_y : r_icon_x;
        c_ic   = c_vert ? r_icon_x : r_icon_y;
        c_lenz = (c_len == 15'd0);
        c_lq   = {c_len, 16'b0};
        c_dpix = $signed({c_ia[15], c_ia}) - $signed({c_wa[15], c_wa});
        c_apx  = {{3{c_dpix[16]}}, c_dpix, 16'b0};
        c_spx  = {9'b0, r_icon_size, 16'b0};
        c_lim  = c_tpos ? c_apx : c_apx + c_spx;
    end

    assign busy = 1'b0;

    // Stage 1: clamp inputs and pick the along and across coordinates.
    logic [16:0] cl_u, cl_v, cl_p;
    logic [16:0] r_s1_ta, r_s1_tc, r_s1_p;
    logic        r_s1_vld;

    always_comb begin
        cl_u = (i_tex_u > Q16_ONE) ? Q16_ONE : i_tex_u;
        cl_v = (i_tex_v > Q16_ONE) ? Q16_ONE : i_tex_v;
        cl_p = (i_progress > Q16_ONE) ? Q16_ONE : i_progress;
    end

    always_ff @(posedge i_clk) begin
        r_s1_ta <= c_vert ? cl_v : cl_u;
        r_s1_tc <= c_vert ? cl_u : cl_v;
        r_s1_p  <= cl_p;
    end

    // Stage 2: position along the side axis.
    logic [30:0] r_s2_q;
    logic [16:0] r_s2_tc, r_s2_p;
    logic        r_s2_vld;

    always_ff @(posedge i_clk) begin
        r_s2_q  <= 31'({14'b0, r_s1_ta} * {16'b0, c_len});
        r_s2_tc <= r_s1_tc;
        r_s2_p  <= r_s1_p;
    end

    // Stage 3: progress product and bend base.
    logic [30:0]        s3_mul_a;
    logic signed [35:0] s3_sq, s3_slq, s3_base, s3_babs;
    logic [47:0]        r_s3_prod;
    logic [30:0]        r_s3_q;
    logic [16:0]        r_s3_tc, r_s3_p;
    logic [33:0]        r_s3_babs;
    logic               r_s3_bneg;
    logic               r_s3_vld;

    always_comb begin
        s3_mul_a = c_tpos ? c_lq - r_s2_q : r_s2_q;
        s3_sq    = $signed({5'b0, r_s2_q});
        s3_slq   = $signed({5'b0, c_lq});
        s3_base  = c_tpos ? c_apx + s3_sq : s3_slq + s3_sq - c_apx - c_spx;
        s3_babs  = s3_base[35] ? -s3_base : s3_base;
    end

    always_ff @(posedge i_clk) begin
        r_s3_prod <= {17'b0, s3_mul_a} * {31'b0, r_s2_p};
        r_s3_q    <= r_s2_q;
        r_s3_tc   <= r_s2_tc;
        r_s3_p    <= r_s2_p;
        r_s3_babs <= s3_babs[33:0];
        r_s3_bneg <= s3_base[35];
    end

    // Cube ratio divider: qf * 2^F / lq.
    logic [30:0]    d1_qf;
    logic [T1W-1:0] d1_tag_in, d1_tag;
    logic [R1W-1:0] d1_quo;
    logic           d1_vld;

    always_comb begin
        d1_qf     = 31'((r_s3_prod + 48'd32768) >> 16) + (c_tpos ? r_s3_q : c_lq - r_s3_q);
        d1_tag_in = {r_s3_q, r_s3_tc, r_s3_p, r_s3_babs, r_s3_bneg};
    end

    mlvw_div #(
        .DEN_W (31),
        .Q_W   (R1W),
        .TAG_W (T1W)
    ) u_div_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s3_vld),
        .i_rem   ({1'b0, d1_qf[30:1]}),
        .i_lo    ({d1_qf[0], {F{1'b0}}}),
        .i_den   (c_lq),
        .i_tag   (d1_tag_in),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_tag   (d1_tag)
    );

    // Stage 4: square the ratio, scale the base by progress.
    logic [R2W-1:0] r_s4_r2p;
    logic [50:0]    r_s4_bp;
    logic [R1W-1:0] r_s4_r;
    logic [30:0]    r_s4_q;
    logic [16:0]    r_s4_tc;
    logic           r_s4_bneg;
    logic           r_s4_vld;

    always_ff @(posedge i_clk) begin
        r_s4_r2p  <= R2W'(d1_quo) * R2W'(d1_quo);
        r_s4_bp   <= 51'(d1_tag[34:1]) * 51'(d1_tag[51:35]);
        r_s4_r    <= d1_quo;
        r_s4_q    <= d1_tag[99:69];
        r_s4_tc   <= d1_tag[68:52];
        r_s4_bneg <= d1_tag[0];
    end

    // Stage 5: rounding.
    logic [R1W-1:0] r_s5_r2, r_s5_r;
    logic [33:0]    r_s5_bpr;
    logic [30:0]    r_s5_q;
    logic [16:0]    r_s5_tc;
    logic           r_s5_bneg;
    logic           r_s5_vld;

    always_ff @(posedge i_clk) begin
        r_s5_r2   <= R1W'((r_s4_r2p + HALF_R2) >> F);
        r_s5_bpr  <= 34'((r_s4_bp + 51'd32768) >> 16);
        r_s5_r    <= r_s4_r;
        r_s5_q    <= r_s4_q;
        r_s5_tc   <= r_s4_tc;
        r_s5_bneg <= r_s4_bneg;
    end

    // Stage 6: cube.
    logic [R2W-1:0] r_s6_r3p;
    logic [33:0]    r_s6_bpr;
    logic [30:0]    r_s6_q;
    logic [16:0]    r_s6_tc;
    logic           r_s6_bneg;
    logic           r_s6_vld;

    always_ff @(posedge i_clk) begin
        r_s6_r3p  <= R2W'(r_s5_r2) * R2W'(r_s5_r);
        r_s6_bpr  <= r_s5_bpr;
        r_s6_q    <= r_s5_q;
        r_s6_tc   <= r_s5_tc;
        r_s6_bneg <= r_s5_bneg;
    end

    // Stage 7: cube rounding; a zero extent gives a ratio of one.
    logic [R1W-1:0] r_s7_r3;
    logic [33:0]    r_s7_bpr;
    logic [30:0]    r_s7_q;
    logic [16:0]    r_s7_tc;
    logic           r_s7_bneg;
    logic           r_s7_vld;

    always_ff @(posedge i_clk) begin
        r_s7_r3   <= c_lenz ? ONE_R : R1W'((r_s6_r3p + HALF_R2) >> F);
        r_s7_bpr  <= r_s6_bpr;
        r_s7_q    <= r_s6_q;
        r_s7_tc   <= r_s6_tc;
        r_s7_bneg <= r_s6_bneg;
    end

    // Stage 8: bend offset product.
    logic [OW-1:0] r_s8_offp;
    logic [30:0]   r_s8_q;
    logic [16:0]   r_s8_tc;
    logic          r_s8_bneg;
    logic          r_s8_vld;

    always_ff @(posedge i_clk) begin
        r_s8_offp <= OW'(r_s7_bpr) * OW'(r_s7_r3);
        r_s8_q    <= r_s7_q;
        r_s8_tc   <= r_s7_tc;
        r_s8_bneg <= r_s7_bneg;
    end

    // Blend factor divider: |offset| * 2^F / |denom|.
    logic [33:0]        d2_offm;
    logic signed [35:0] d2_sq, d2_den, d2_dabs;
    logic               d2_dneg, d2_dzero;
    logic [T2W-1:0]     d2_tag_in, d2_tag;
    logic [BLW-1:0]     d2_quo;
    logic               d2_vld;

    always_comb begin
        d2_offm   = 34'((r_s8_offp + HALF_O) >> F);
        d2_sq     = $signed({5'b0, r_s8_q});
        d2_den    = c_tpos ? c_apx - d2_sq : d2_sq - c_apx - c_spx;
        d2_dneg   = d2_den[35];
        d2_dabs   = d2_dneg ? -d2_den : d2_den;
        d2_dzero  = (d2_den == 36'sd0);
        d2_tag_in = {r_s8_q, r_s8_tc, d2_offm, r_s8_bneg, r_s8_bneg ^ d2_dneg, d2_dzero};
    end

    mlvw_div #(
        .DEN_W (33),
        .Q_W   (BLW),
        .TAG_W (T2W)
    ) u_div_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s8_vld),
        .i_rem   (33'd0),
        .i_lo    ({d2_offm, {F{1'b0}}}),
        .i_den   (d2_dabs[32:0]),
        .i_tag   (d2_tag_in),
        .o_vld   (d2_vld),
        .o_quo   (d2_quo),
        .o_tag   (d2_tag)
    );

    // Stage 9: blend factor, clamped along position, across products.
    logic signed [35:0] s9_off, s9_sq, s9_raw, s9_pos;
    logic [BLW-1:0]     s9_bl;
    logic signed [35:0] r_s9_pos;
    logic [BLW-1:0]     r_s9_bl;
    logic [30:0]        r_s9_tl;
    logic [26:0]        r_s9_st;
    logic               r_s9_vld;

    always_comb begin
        s9_off = d2_tag[2] ? -$signed({2'b0, d2_tag[36:3]}) : $signed({2'b0, d2_tag[36:3]});
        s9_sq  = $signed({5'b0, d2_tag[84:54]});
        s9_raw = c_tpos ? s9_sq + s9_off : s9_sq - s9_off;
        if (c_tpos) begin
            s9_pos = (s9_raw > c_lim) ? c_lim : s9_raw;
        end else begin
            s9_pos = (s9_raw < c_lim) ? c_lim : s9_raw;
        end
        if (d2_tag[0]) begin
            s9_bl = ONE_BL;
        end else if (!d2_tag[1] && d2_quo > ONE_BL) begin
            s9_bl = ONE_BL;
        end else begin
            s9_bl = d2_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s9_pos <= s9_pos;
        r_s9_bl  <= s9_bl;
        r_s9_tl  <= 31'({14'b0, d2_tag[53:37]} * {16'b0, c_lenc});
        r_s9_st  <= 27'({10'b0, d2_tag[53:37]} * {16'b0, r_icon_size});
    end

    // Stage 10: screen positions and the across distance.
    logic signed [34:0] s10_absc, s10_target, s10_diff, s10_dabs;
    logic signed [37:0] r_s10_along;
    logic signed [34:0] r_s10_absc;
    logic [33:0]        r_s10_dmag;
    logic               r_s10_dneg;
    logic [BLW-1:0]     r_s10_bl;
    logic               r_s10_vld;

    always_comb begin
        s10_absc   = $signed({{3{c_wc[15]}}, c_wc, 16'b0}) + $signed({4'b0, r_s9_tl});
        s10_target = $signed({{3{c_ic[15]}}, c_ic, 16'b0}) + $signed({8'b0, r_s9_st});
        s10_diff   = s10_target - s10_absc;
        s10_dabs   = s10_diff[34] ? -s10_diff : s10_diff;
    end

    always_ff @(posedge i_clk) begin
        r_s10_along <= $signed({{6{c_wa[15]}}, c_wa, 16'b0})
                     + $signed({{2{r_s9_pos[35]}}, r_s9_pos});
        r_s10_absc  <= s10_absc;
        r_s10_dmag  <= s10_dabs[33:0];
        r_s10_dneg  <= s10_diff[34];
        r_s10_bl    <= r_s9_bl;
    end

    // Stage 11: blend product in two halves; along output rounding.
    logic [LOW-1:0]     r_s11_plo;
    logic [HIW-1:0]     r_s11_phi;
    logic signed [23:0] r_s11_oa;
    logic signed [34:0] r_s11_absc;
    logic               r_s11_dneg;
    logic               r_s11_vld;

    always_ff @(posedge i_clk) begin
        r_s11_plo  <= LOW'(r_s10_dmag) * LOW'(r_s10_bl[BLO-1:0]);
        r_s11_phi  <= HIW'(r_s10_dmag) * HIW'(r_s10_bl[BLW-1:BLO]);
        r_s11_oa   <= round_out({{5{r_s10_along[37]}}, r_s10_along});
        r_s11_absc <= r_s10_absc;
        r_s11_dneg <= r_s10_dneg;
    end

    // Stage 12: recombine the halves.
    logic [PW-1:0]      r_s12_sum;
    logic signed [23:0] r_s12_oa;
    logic signed [34:0] r_s12_absc;
    logic               r_s12_dneg;
    logic               r_s12_vld;

    always_ff @(posedge i_clk) begin
        r_s12_sum  <= {r_s11_phi, {BLO{1'b0}}} + PW'(r_s11_plo);
        r_s12_oa   <= r_s11_oa;
        r_s12_absc <= r_s11_absc;
        r_s12_dneg <= r_s11_dneg;
    end

    // Stage 13: round, cap far beyond the output range, add the start position.
    logic [PW-1:0]          s13_pm;
    logic [40:0]            s13_cap;
    logic signed [ACC_W-1:0] s13_ps;
    logic signed [ACC_W-1:0] r_s13_across;
    logic signed [23:0]     r_s13_oa;
    logic                   r_s13_vld;

    always_comb begin
        s13_pm  = (r_s12_sum + HALF_P) >> F;
        s13_cap = (s13_pm > P_CAP) ? P_CAP[40:0] : s13_pm[40:0];
        s13_ps  = r_s12_dneg ? -$signed({2'b0, s13_cap}) : $signed({2'b0, s13_cap});
    end

    always_ff @(posedge i_clk) begin
        r_s13_across <= s13_ps + $signed({{8{r_s12_absc[34]}}, r_s12_absc});
        r_s13_oa     <= r_s12_oa;
    end

    // Output registers.
    logic signed [23:0] s14_oc;
    logic signed [23:0] r_out_x, r_out_y;
    logic               r_done;

    assign s14_oc = round_out(r_s13_across);

    always_ff @(posedge i_clk) begin
        r_out_x <= c_vert ? s14_oc : r_s13_oa;
        r_out_y <= c_vert ? r_s13_oa : s14_oc;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
            r_s13_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_s1_vld  <= start;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= d1_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= d2_vld;
            r_s10_vld <= r_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
            r_s13_vld <= r_s12_vld;
            r_done    <= r_s13_vld;
        end
    end

    assign o_done  = r_done;
    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;

endmodule

// ===== src/mlvw_div.sv =====
// ----------------------------------------------------------------------------
// mlvw_div: pipelined restoring divider
// One quotient bit per register stage, one item per cycle, tag carried along.
// ----------------------------------------------------------------------------
module mlvw_div #(
    parameter int DEN_W = 31,
    parameter int Q_W   = 17,
    parameter int TAG_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [Q_W-1:0]   i_lo,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [Q_W-1:0]   o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [DEN_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_lo  [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [TAG_W-1:0] r_tag [Q_W];
    logic [Q_W-1:0]   r_vld;

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [DEN_W-1:0] cur_rem;
        logic [DEN_W-1:0] cur_den;
        logic [Q_W-1:0]   cur_lo;
        logic [TAG_W-1:0] cur_tag;
        logic             cur_vld;
        logic [DEN_W:0]   trial_in;
        logic [DEN_W:0]   trial_sub;
        logic             take;

        if (k == 0) begin : g_first
            assign cur_rem = i_rem;
            assign cur_den = i_den;
            assign cur_lo  = i_lo;
            assign cur_tag = i_tag;
            assign cur_vld = i_vld;
        end else begin : g_next
            assign cur_rem = r_rem[k-1];
            assign cur_den = r_den[k-1];
            assign cur_lo  = r_lo[k-1];
            assign cur_tag = r_tag[k-1];
            assign cur_vld = r_vld[k-1];
        end

        assign trial_in  = {cur_rem, cur_lo[Q_W-1]};
        assign take      = trial_in >= {1'b0, cur_den};
        assign trial_sub = trial_in - {1'b0, cur_den};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= take ? trial_sub[DEN_W-1:0] : trial_in[DEN_W-1:0];
            r_lo[k]  <= {cur_lo[Q_W-2:0], take};
            r_den[k] <= cur_den;
            r_tag[k] <= cur_tag;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= cur_vld;
            end
        end
    end

    assign o_vld = r_vld[Q_W-1];
    assign o_quo = r_lo[Q_W-1];
    assign o_tag = r_tag[Q_W-1];

endmodule

// ===== test/mlvw_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mlvw_checker: prediction and comparison for the vertex warp
// Tracks the configuration registers and every accepted item, works out the
// deformed position of each vertex and compares it with each strobed result.
// ----------------------------------------------------------------------------
module mlvw_checker import mlvw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [16:0]        i_tex_u,
    input  logic [16:0]        i_tex_v,
    input  logic [16:0]        i_progress,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_done,
    input  logic signed [23:0] i_out_x,
    input  logic signed [23:0] i_out_y,
    output int                 o_errors,
    output int                 o_pending
);

    localparam longint unsigned CAP = 64'd1 << 62;
    localparam longint ONE_PIX = 65536;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
    } t_pos;

    logic signed [15:0] wx, wy, ix, iy;
    logic [14:0]        ww, wh;
    logic [10:0]        isz;
    t_side              sd;
    t_pos               pos_q[$];
    int                 errors;

    function automatic longint unsigned magn(input longint a);
        return (a < 0) ? 64'd0 - longint'(a) : a;
    endfunction

    function automatic longint with_sign(input longint unsigned m, input bit neg);
        longint unsigned c;
        c = (m > CAP) ? CAP : m;
        return neg ? -longint'(c) : longint'(c);
    endfunction

    function automatic longint mul_round(input longint a, input longint b, input int s);
        longint unsigned ua, ub, m;
        ua = magn(a);
        ub = magn(b);
        if (ua != 0 && ub > CAP / ua) begin
            m = CAP;
        end else begin
            m = ua * ub;
            if (s > 0) m = (m + (64'd1 << (s - 1))) >> s;
        end
        return with_sign(m, (a < 0) != (b < 0));
    endfunction

    function automatic longint div_trunc(input longint n, input longint d, input int s);
        longint unsigned un, ud, m;
        un = magn(n);
        ud = magn(d);
        if (ud == 0) return 0;
        if ((un >> (62 - s)) != 0) m = CAP;
        else m = (un << s) / ud;
        return with_sign(m, (n < 0) != (d < 0));
    endfunction

    function automatic void bend(input longint ta, input longint tc, input longint p,
                                 input longint len, input longint len_c,
                                 input longint wa, input longint wc,
                                 input longint ia, input longint ic, input longint sz,
                                 input bit toward_pos,
                                 output longint along, output longint across);
        longint one, q, lq, apx, spx, qf, r, r3, base, denom, lim, offset, blend;
        longint p_al, abs_c, target;
        one = longint'(1) << FRAC_BITS_DEF;
        q = ta * len;
        lq = len * ONE_PIX;
        apx = (ia - wa) * ONE_PIX;
        spx = sz * ONE_PIX;
        qf = toward_pos ? q + mul_round(lq - q, p, 16) : (lq - q) + mul_round(q, p, 16);
        if (len == 0) begin
            r3 = one;
        end else begin
            r = div_trunc(qf, lq, FRAC_BITS_DEF);
            r3 = mul_round(mul_round(r, r, FRAC_BITS_DEF), r, FRAC_BITS_DEF);
        end
        if (toward_pos) begin
            base = apx + q;
            denom = apx - q;
            lim = apx;
        end else begin
            base = lq + q - apx - spx;
            denom = q - apx - spx;
            lim = apx + spx;
        end
        offset = mul_round(mul_round(base, p, 16), r3, FRAC_BITS_DEF);
        if (denom == 0) begin
            blend = one;
        end else begin
            blend = div_trunc(offset, denom, FRAC_BITS_DEF);
            if (blend > one) blend = one;
        end
        if (blend < 0) blend = -blend;
        if (toward_pos) begin
            p_al = q + offset;
            if (p_al > lim) p_al = lim;
        end else begin
            p_al = q - offset;
            if (p_al < lim) p_al = lim;
        end
        along = wa * ONE_PIX + p_al;
        abs_c = tc * len_c + wc * ONE_PIX;
        target = ic * ONE_PIX + sz * tc;
        across = mul_round(target - abs_c, blend, FRAC_BITS_DEF) + abs_c;
    endfunction

    function automatic logic signed [23:0] to_pixel8(input longint v16);
        longint v8;
        v8 = mul_round(v16, 1, 8);
        if (v8 > 8388607) v8 = 8388607;
        if (v8 < -8388608) v8 = -8388608;
        return v8[23:0];
    endfunction

    function automatic longint sat_q16(input logic [16:0] v);
        return (v > Q16_ONE) ? ONE_PIX : longint'(v);
    endfunction

    function automatic t_pos warp_vertex(input logic [16:0] u_in, input logic [16:0] v_in,
                                         input logic [16:0] p_in);
        longint u, v, p, x16, y16;
        t_pos   res;
        u = sat_q16(u_in);
        v = sat_q16(v_in);
        p = sat_q16(p_in);
        if (sd == SIDE_BOTTOM || sd == SIDE_TOP) begin
            bend(v, u, p, longint'(wh), longint'(ww), longint'(wy), longint'(wx),
                 longint'(iy), longint'(ix), longint'(isz), sd == SIDE_BOTTOM, y16, x16);
        end else begin
            bend(u, v, p, longint'(ww), longint'(wh), longint'(wx), longint'(wy),
                 longint'(ix), longint'(iy), longint'(isz), sd == SIDE_RIGHT, x16, y16);
        end
        res.x = to_pixel8(x16);
        res.y = to_pixel8(y16);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pos want;
        if (!i_rst_n) begin
            wx <= '0;
            wy <= '0;
            ww <= WIN_W_RST;
            wh <= WIN_H_RST;
            ix <= '0;
            iy <= '0;
            isz <= ICON_SIZE_RST;
            sd <= SIDE_BOTTOM;
            pos_q.delete();
        end else begin
            if (i_start && !i_busy) pos_q.push_back(warp_vertex(i_tex_u, i_tex_v, i_progress));
            if (i_done) begin
                if (pos_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("Unexpected result x=%0d y=%0d", i_out_x, i_out_y);
                end else begin
                    want = pos_q.pop_front();
                    if (want.x !== i_out_x || want.y !== i_out_y) begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                     want.x, want.y, i_out_x, i_out_y);
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WIN_X:     wx <= i_cfg_wdata;
                    CFG_WIN_Y:     wy <= i_cfg_wdata;
                    CFG_WIN_W:     ww <= i_cfg_wdata[14:0];
                    CFG_WIN_H:     wh <= i_cfg_wdata[14:0];
                    CFG_ICON_X:    ix <= i_cfg_wdata;
                    CFG_ICON_Y:    iy <= i_cfg_wdata;
                    CFG_ICON_SIZE: isz <= i_cfg_wdata[10:0];
                    CFG_SIDE:      sd <= t_side'(i_cfg_wdata[1:0]);
                    default: ;
                endcase
            end
        end
    end

    initial errors = 0;
    assign o_errors = errors;
    assign o_pending = pos_q.size();

endmodule

// ===== test/magic_lamp_vertex_warp_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// magic_lamp_vertex_warp_tb: stimulus and verdict for the vertex warp
// Sets several window and icon layouts on every side, sends directed corner
// vertices and random vertices with varying gaps, and reports the verdict.
// ----------------------------------------------------------------------------
module magic_lamp_vertex_warp_tb;
    import mlvw_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [16:0]        i_tex_u, i_tex_v, i_progress;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_idx;
    logic [15:0]        i_cfg_wdata;
    logic               o_done;
    logic signed [23:0] o_out_x, o_out_y;
    int                 errors, pending, idle_pct;

    magic_lamp_vertex_warp u_top (.*);

    mlvw_checker u_chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_tex_u, .i_tex_v,
        .i_progress, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata, .i_done(o_done),
        .i_out_x(o_out_x), .i_out_y(o_out_y), .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_vertex(input logic [16:0] u, input logic [16:0] v, input logic [16:0] p);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_tex_u <= u;
        i_tex_v <= v;
        i_progress <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_layout(input logic [15:0] wx, input logic [15:0] wy,
                              input logic [15:0] ww, input logic [15:0] wh,
                              input logic [15:0] ix, input logic [15:0] iy,
                              input logic [15:0] isz, input t_side sd);
        write_reg(CFG_WIN_X, wx);
        write_reg(CFG_WIN_Y, wy);
        write_reg(CFG_WIN_W, ww);
        write_reg(CFG_WIN_H, wh);
        write_reg(CFG_ICON_X, ix);
        write_reg(CFG_ICON_Y, iy);
        write_reg(CFG_ICON_SIZE, isz);
        write_reg(CFG_SIDE, {14'd0, sd});
    endtask

    function automatic logic [16:0] rand_q16();
        if ($urandom_range(9) < 2) return 17'($urandom);
        if ($urandom_range(9) < 1) return ($urandom_range(1)) ? Q16_ONE : 17'd0;
        return 17'($urandom_range(65536));
    endfunction

    initial begin
        logic [16:0] corner[3];
        corner = '{17'd0, Q16_ONE, 17'h1FFFF};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_tex_u = '0;
        i_tex_v = '0;
        i_progress = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_WIN_X;
        i_cfg_wdata = '0;
        idle_pct = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < 9; k++) send_vertex(corner[k % 3], corner[k / 3], 17'd32768);
        send_vertex(17'd0, 17'd0, 17'd0);
        send_vertex(Q16_ONE, Q16_ONE, Q16_ONE);
        send_vertex(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        drain();

        // Icon edge meets the window edge on the far row: zero blend denominator.
        set_layout(16'd0, 16'd0, 16'd640, 16'd480, 16'd100, 16'd480, 16'd40, SIDE_BOTTOM);
        send_vertex(17'd0, Q16_ONE, 17'd40000);
        send_vertex(17'd12345, Q16_ONE, Q16_ONE);
        drain();
        for (int s = 0; s < 4; s++) begin
            // Zero extent along the side axis.
            set_layout(16'h8000, 16'h7FFF, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'h7FF, t_side'(s));
            send_vertex(17'd30000, 17'd20000, 17'd50000);
            send_vertex(Q16_ONE, Q16_ONE, 17'd1);
            drain();
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 62;
                2: idle_pct = 0;
                default: idle_pct = 32;
            endcase
            case (ph)
                0: set_layout(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                              16'h7FFF, 16'h7FFF, 16'h7FF, SIDE_BOTTOM);
                1: set_layout(16'h7FFF, 16'h7FFF, 16'd1, 16'd1, 16'h8000, 16'h8000, 16'd1, SIDE_TOP);
                2: set_layout(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, SIDE_RIGHT);
                3: set_layout(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom), t_side'($urandom));
                default: set_layout(16'($urandom_range(2000)), 16'($urandom_range(2000)),
                                    16'($urandom_range(16384, 1)), 16'($urandom_range(16384, 1)),
                                    16'($urandom_range(4000)), 16'($urandom_range(4000)),
                                    16'($urandom_range(1024, 1)), t_side'(ph % 4));
            endcase
            for (int n = 0; n < 106; n++) begin
                if (ph % 2 == 1 && n % 30 == 0) idle_pct = (idle_pct == 0) ? 62 - 30 * (ph % 4 / 3)
                                                                          : 0;
                send_vertex(rand_q16(), rand_q16(), rand_q16());
            end
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
